### rtl/core/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and codes for the token literal classifier: recognizer phases,
// class codes and the control word passed to the recognizer.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ClassW = 3;

  typedef enum logic [3:0] {
    NP_START = 4'd0,
    NP_SIGN  = 4'd1,
    NP_INT   = 4'd2,
    NP_DOT   = 4'd3,
    NP_FRAC  = 4'd4,
    NP_EXP   = 4'd5,
    NP_ESIGN = 4'd6,
    NP_EDIG  = 4'd7,
    NP_DEAD  = 4'd15
  } num_phase_t;

  typedef enum logic [1:0] {
    SP_START  = 2'd0,
    SP_OPEN   = 2'd1,
    SP_CLOSED = 2'd2,
    SP_DEAD   = 2'd3
  } str_phase_t;

  typedef enum logic [ClassW-1:0] {
    CLS_NONE   = 3'd0,
    CLS_STRING = 3'd1,
    CLS_FLOAT  = 3'd2,
    CLS_INT    = 3'd3,
    CLS_IDENT  = 3'd4
  } token_class_t;

  typedef struct packed {
    logic step;
    logic last;
  } rec_ctrl_t;

  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUA    = 8'h41;
  localparam logic [CharW-1:0] ChUE    = 8'h45;
  localparam logic [CharW-1:0] ChUZ    = 8'h5A;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChLA    = 8'h61;
  localparam logic [CharW-1:0] ChLE    = 8'h65;
  localparam logic [CharW-1:0] ChLZ    = 8'h7A;

endpackage

### rtl/core/tlc_if.sv
// ----------------------------------------------------------------------------
// tlc_if
// Valid/ready channels of the classifier: byte words in, class words out.
// ----------------------------------------------------------------------------
interface tlc_in_if;
  logic                     valid;
  logic                     ready;
  logic [tlc_pkg::CharW-1:0] char_byte;
  logic                     last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface tlc_out_if;
  logic                      valid;
  logic                      ready;
  logic [tlc_pkg::ClassW-1:0] token_class;

  modport source (output valid, output token_class, input ready);
  modport sink   (input valid, input token_class, output ready);
endinterface

### rtl/core/tlc_recognizer.sv
// ----------------------------------------------------------------------------
// tlc_recognizer
// String, number and identifier recognizers. Holds the token state, advances
// it on each stepped byte and gives the class the token would have if this
// byte were its last. State returns to start after the final byte.
// ----------------------------------------------------------------------------
module tlc_recognizer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tlc_pkg::rec_ctrl_t        ctrl,
  input  logic [tlc_pkg::CharW-1:0] char_byte,
  output tlc_pkg::token_class_t     token_class
);

  tlc_pkg::num_phase_t num_r, num_nxt;
  tlc_pkg::str_phase_t str_r, str_nxt;
  logic                ident_r, ident_nxt;
  logic                start_r;

  logic is_digit, is_alpha, is_sign, is_exp;

  always_comb begin
    is_digit = (char_byte >= tlc_pkg::Ch0) && (char_byte <= tlc_pkg::Ch9);
    is_alpha = ((char_byte >= tlc_pkg::ChLA) && (char_byte <= tlc_pkg::ChLZ)) ||
               ((char_byte >= tlc_pkg::ChUA) && (char_byte <= tlc_pkg::ChUZ)) ||
               (char_byte == tlc_pkg::ChUnder);
    is_sign  = (char_byte == tlc_pkg::ChPlus) || (char_byte == tlc_pkg::ChMinus);
    is_exp   = (char_byte == tlc_pkg::ChLE) || (char_byte == tlc_pkg::ChUE);
  end

  always_comb begin
    num_nxt = tlc_pkg::NP_DEAD;
    unique case (num_r)
      tlc_pkg::NP_START: begin
        if (is_sign)                       num_nxt = tlc_pkg::NP_SIGN;
        else if (is_digit)                 num_nxt = tlc_pkg::NP_INT;
        else if (char_byte == tlc_pkg::ChDot) num_nxt = tlc_pkg::NP_DOT;
      end
      tlc_pkg::NP_SIGN: begin
        if (is_digit)                      num_nxt = tlc_pkg::NP_INT;
        else if (char_byte == tlc_pkg::ChDot) num_nxt = tlc_pkg::NP_DOT;
      end
      tlc_pkg::NP_INT: begin
        if (is_digit)                      num_nxt = tlc_pkg::NP_INT;
        else if (char_byte == tlc_pkg::ChDot) num_nxt = tlc_pkg::NP_DOT;
        else if (is_exp)                   num_nxt = tlc_pkg::NP_EXP;
      end
      tlc_pkg::NP_DOT: begin
        if (is_digit) num_nxt = tlc_pkg::NP_FRAC;
      end
      tlc_pkg::NP_FRAC: begin
        if (is_digit)    num_nxt = tlc_pkg::NP_FRAC;
        else if (is_exp) num_nxt = tlc_pkg::NP_EXP;
      end
      tlc_pkg::NP_EXP: begin
        if (is_sign)       num_nxt = tlc_pkg::NP_ESIGN;
        else if (is_digit) num_nxt = tlc_pkg::NP_EDIG;
      end
      tlc_pkg::NP_ESIGN, tlc_pkg::NP_EDIG: begin
        if (is_digit) num_nxt = tlc_pkg::NP_EDIG;
      end
      default: num_nxt = tlc_pkg::NP_DEAD;
    endcase
  end

  always_comb begin
    unique case (str_r)
      tlc_pkg::SP_START:
        str_nxt = (char_byte == tlc_pkg::ChQuote) ? tlc_pkg::SP_OPEN : tlc_pkg::SP_DEAD;
      tlc_pkg::SP_OPEN, tlc_pkg::SP_CLOSED:
        str_nxt = (char_byte == tlc_pkg::ChQuote) ? tlc_pkg::SP_CLOSED : tlc_pkg::SP_OPEN;
      default:
        str_nxt = tlc_pkg::SP_DEAD;
    endcase
  end

  always_comb begin
    if (start_r) ident_nxt = is_alpha;
    else         ident_nxt = ident_r && (is_alpha || is_digit);
  end

  always_comb begin
    if (str_nxt == tlc_pkg::SP_CLOSED)
      token_class = tlc_pkg::CLS_STRING;
    else if (num_nxt == tlc_pkg::NP_INT)
      token_class = tlc_pkg::CLS_INT;
    else if ((num_nxt == tlc_pkg::NP_FRAC) || (num_nxt == tlc_pkg::NP_EDIG))
      token_class = tlc_pkg::CLS_FLOAT;
    else if (ident_nxt)
      token_class = tlc_pkg::CLS_IDENT;
    else
      token_class = tlc_pkg::CLS_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (ctrl.step && ctrl.last)) begin
      num_r   <= tlc_pkg::NP_START;
      str_r   <= tlc_pkg::SP_START;
      ident_r <= 1'b1;
      start_r <= 1'b1;
    end else if (ctrl.step) begin
      num_r   <= num_nxt;
      str_r   <= str_nxt;
      ident_r <= ident_nxt;
      start_r <= 1'b0;
    end
  end

endmodule

### rtl/core/token_literal_classifier.sv
// ----------------------------------------------------------------------------
// token_literal_classifier
// Classifies a token streamed one byte per word as string, integer, float,
// identifier or none.
// ----------------------------------------------------------------------------
// Bytes enter an input register, pass through the recognizer logic and the
// class of the token lands in an output register on its final byte; other
// bytes give no word. One byte is taken every cycle unless a final byte is
// held back in the input register. While a class word waits unaccepted,
// bytes keep flowing until the next final byte reaches the input register,
// which then holds until the output is taken.
module token_literal_classifier (
  input  logic       clk,
  input  logic       rst_n,
  tlc_in_if.sink     in_ch,
  tlc_out_if.source  out_ch
);

  logic                      s1_v_r;
  logic                      s1_last_r;
  logic [tlc_pkg::CharW-1:0] s1_byte_r;
  logic                      out_v_r;
  tlc_pkg::token_class_t     out_cls_r;

  tlc_pkg::rec_ctrl_t    ctrl;
  tlc_pkg::token_class_t cls;
  logic                  advance;

  assign advance      = s1_v_r && (!s1_last_r || !out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || advance;
  assign ctrl.step    = advance;
  assign ctrl.last    = s1_last_r;

  tlc_recognizer u_rec (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .char_byte   (s1_byte_r),
    .token_class (cls)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.char_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (advance && s1_last_r) begin
      out_cls_r <= cls;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.token_class = out_cls_r;

  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_cls_r <= tlc_pkg::CLS_IDENT))
    else $error("class code out of range");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_last_r && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("final byte advanced over a waiting class word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !s1_v_r))
    else $error("pipeline not empty after reset");

endmodule
